>>> sv/drc_pkg.sv
package drc_pkg;

    localparam int TableDepth = 16;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    typedef enum logic [2:0] {
        ST_STORED = 3'd0,
        ST_DUP    = 3'd1,
        ST_OFF    = 3'd2,
        ST_FULL   = 3'd3,
        ST_DRAIN  = 3'd4,
        ST_EMPTY  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLIP,
        S_WALK,
        S_AREA,
        S_MATH,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
    } t_rect;

    typedef struct packed {
        logic load;
        logic clip;
        logic rd;
        logic judge;
        logic finish;
        logic drain_rd;
        logic drain_emit;
    } t_cmd;

    typedef struct packed {
        logic is_drain;
        logic walk_done;
        logic drain_done;
        logic empty;
    } t_stat;

endpackage

>>> sv/drc_ctrl.sv
module drc_ctrl import drc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLIP;
                end
            end
            S_CLIP: begin
                if (i_stat.is_drain) begin
                    if (i_stat.empty) begin
                        o_cmd.drain_emit = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.drain_rd = 1'b1;
                        n_state        = S_DRAIN;
                    end
                end else begin
                    o_cmd.clip = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_AREA;
                end
            end
            // wait in S_AREA while the area products settle
            S_AREA: n_state = S_MATH;
            S_MATH: begin
                o_cmd.judge = 1'b1;
                n_state     = S_WALK;
            end
            S_DRAIN: begin
                o_cmd.drain_emit = 1'b1;
                if (i_stat.drain_done) n_state = S_IDLE;
                else                   o_cmd.drain_rd = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> sv/drc_datapath.sv
module drc_datapath import drc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_kind,
    input  logic [14:0] i_rect_left,
    input  logic [14:0] i_rect_top,
    input  logic [13:0] i_rect_width,
    input  logic [13:0] i_rect_height,
    input  logic [13:0] i_sw,
    input  logic [13:0] i_sh,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [12:0] o_out_left,
    output logic [12:0] o_out_top,
    output logic [13:0] o_out_width,
    output logic [13:0] o_out_height,
    output logic [4:0]  o_entry_count,
    output logic        o_last
);

    t_rect mem [TableDepth];
    t_rect r_e, r_c, r_nr;
    logic  r_kind, r_add, r_off;
    logic signed [15:0] r_il, r_it;
    logic [13:0] r_iw, r_ih;
    logic [CntW-1:0] r_cnt, r_rd, r_kept;
    logic [29:0] r_ea, r_ca;
    logic [29:0] r_ba;

    // clipped size limits
    logic [14:0] sw, sh;
    assign sw = (i_sw == 14'd0) ? 15'd1 : (i_sw > 14'd8192 ? 15'd8192 : {1'b0, i_sw});
    assign sh = (i_sh == 14'd0) ? 15'd1 : (i_sh > 14'd8192 ? 15'd8192 : {1'b0, i_sh});

    logic signed [16:0] ir, ib, cr, cb;
    logic ov;
    always_comb begin
        ir = 17'(r_il) + 17'(signed'({1'b0, r_iw})) - 17'sd1;
        ib = 17'(r_it) + 17'(signed'({1'b0, r_ih})) - 17'sd1;
        cr = 17'(signed'({2'b0, sw})) - 17'sd1;
        cb = 17'(signed'({2'b0, sh})) - 17'sd1;
        ov = (17'sd0 < ir) && (cr > 17'(r_il)) && (17'sd0 < ib) && (cb > 17'(r_it));
    end

    logic signed [16:0] cl, ct, rr, rb, cw, ch;
    always_comb begin
        cl = (r_il > 16'sd0) ? 17'(r_il) : 17'sd0;
        ct = (r_it > 16'sd0) ? 17'(r_it) : 17'sd0;
        rr = (ir < cr) ? ir : cr;
        rb = (ib < cb) ? ib : cb;
        cw = rr - cl + 17'sd1;
        ch = rb - ct + 17'sd1;
    end

    // entry versus clipped rect
    logic signed [16:0] er, eb, kr, kb, bl, bt, br2, bb2;
    logic e_ov;
    always_comb begin
        er   = 17'(r_e.left) + 17'(signed'({1'b0, r_e.width})) - 17'sd1;
        eb   = 17'(r_e.top) + 17'(signed'({1'b0, r_e.height})) - 17'sd1;
        kr   = 17'(r_c.left) + 17'(signed'({1'b0, r_c.width})) - 17'sd1;
        kb   = 17'(r_c.top) + 17'(signed'({1'b0, r_c.height})) - 17'sd1;
        e_ov = (r_c.left < 16'(er)) && (kr > 17'(r_e.left)) &&
               (r_c.top < 16'(eb)) && (kb > 17'(r_e.top));
        bl   = (r_e.left < r_c.left) ? 17'(r_e.left) : 17'(r_c.left);
        bt   = (r_e.top < r_c.top) ? 17'(r_e.top) : 17'(r_c.top);
        br2  = (er > kr) ? er : kr;
        bb2  = (eb > kb) ? eb : kb;
    end

    logic [14:0] bw, bh;
    assign bw = 15'(br2 - bl + 17'sd1);
    assign bh = 15'(bb2 - bt + 17'sd1);

    logic keep_w, full_w, same_w;
    assign same_w = (r_e == r_c);
    assign full_w = (r_kept >= CntW'(TableDepth));
    assign keep_w = same_w || !e_ov || (r_ba > r_ea + r_ca);

    // bounding-box area product, registered into r_ba ahead of judge
    logic [29:0] n_ba;
    assign n_ba = 30'(bw) * 30'(bh);

    assign o_stat.is_drain   = r_kind;
    assign o_stat.empty      = (r_cnt == '0);
    assign o_stat.walk_done  = (r_rd >= r_cnt);
    assign o_stat.drain_done = (r_rd >= r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd || i_cmd.drain_rd) r_e <= mem[r_rd[IdxW-1:0]];
        if (i_cmd.judge && keep_w)
            mem[r_kept[IdxW-1:0]] <= r_e;
        if (i_cmd.finish && !r_off && r_add && !full_w)
            mem[r_kept[IdxW-1:0]] <= r_nr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish || i_cmd.drain_emit;
            if (i_cmd.load) begin
                r_kind <= i_kind;
                r_il   <= 16'(signed'(i_rect_left));
                r_it   <= 16'(signed'(i_rect_top));
                r_iw   <= i_rect_width;
                r_ih   <= i_rect_height;
                r_rd   <= '0;
                r_kept <= '0;
                r_add  <= 1'b1;
            end
            if (i_cmd.clip) begin
                r_off         <= !ov;
                r_c.left      <= 16'(cl);
                r_c.top       <= 16'(ct);
                r_c.width     <= 15'(cw);
                r_c.height    <= 15'(ch);
                r_nr.left     <= 16'(cl);
                r_nr.top      <= 16'(ct);
                r_nr.width    <= 15'(cw);
                r_nr.height   <= 15'(ch);
                r_ca          <= 30'(15'(cw)) * 30'(15'(ch));
                if (!ov) r_rd <= r_cnt;
            end
            if (i_cmd.rd) r_rd <= r_rd + 1'b1;
            if (i_cmd.drain_rd) r_rd <= r_rd + 1'b1;
            if (i_cmd.judge) begin
                if (same_w) r_add <= 1'b0;
                if (keep_w) r_kept <= r_kept + 1'b1;
                else begin
                    r_nr.left   <= 16'(bl);
                    r_nr.top    <= 16'(bt);
                    r_nr.width  <= bw;
                    r_nr.height <= bh;
                end
            end
            if (i_cmd.finish) begin
                o_last <= 1'b1;
                if (r_off) begin
                    o_status <= ST_OFF;
                    {o_out_left, o_out_top, o_out_width, o_out_height} <= '0;
                    o_entry_count <= 5'(r_cnt);
                end else begin
                    r_cnt <= r_kept + ((r_add && !full_w) ? 1'b1 : 1'b0);
                    o_entry_count <= 5'(r_kept + ((r_add && !full_w) ? 1'b1 : 1'b0));
                    o_status <= !r_add ? ST_DUP : (full_w ? ST_FULL : ST_STORED);
                    o_out_left   <= 13'(!r_add ? r_c.left : r_nr.left);
                    o_out_top    <= 13'(!r_add ? r_c.top : r_nr.top);
                    o_out_width  <= 14'(!r_add ? r_c.width : r_nr.width);
                    o_out_height <= 14'(!r_add ? r_c.height : r_nr.height);
                end
            end
            if (i_cmd.drain_emit) begin
                o_entry_count <= '0;
                if (r_cnt == '0) begin
                    o_status <= ST_EMPTY;
                    o_last   <= 1'b1;
                    {o_out_left, o_out_top, o_out_width, o_out_height} <= '0;
                end else begin
                    o_status     <= ST_DRAIN;
                    o_last       <= (r_rd >= r_cnt);
                    o_out_left   <= 13'(r_e.left);
                    o_out_top    <= 13'(r_e.top);
                    o_out_width  <= 14'(r_e.width);
                    o_out_height <= 14'(r_e.height);
                    if (r_rd >= r_cnt) r_cnt <= '0;
                end
            end
        end
    end

    // stage areas the cycle after the entry is read
    always_ff @(posedge i_clk) begin
        r_ea <= 30'(r_e.width) * 30'(r_e.height);
        r_ba <= n_ba;
    end

endmodule

>>> sv/dirty_rect_coalescing_table.sv
// Dirty rectangle coalescing table.
// Command channel: raise start with kind and the rectangle fields; the word is
// taken at a clock edge where start is high and busy is low. busy drops in the
// cycle that shows the last result of that word, so the next word can be taken
// at the edge that ends that cycle.
// Results appear on o_status and the rectangle ports for one cycle each,
// flagged by o_valid; o_last marks the final result of a command.
// An add runs from the accepting edge through clip, then per stored entry a
// read, an area stage and a compare/compact step, then the append, walking
// one stored entry at a time. A drain reads its first entry in the clip state
// and emits it from the drain state, then shows one entry per cycle; an empty
// drain answers straight from the clip state.
// Config port: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; index 0
// is screen width, 1 screen height. o_cfg_ready is always high.
// Reset (synchronous, active low) empties the table and loads 1024 x 768.
// The receiver cannot stall: every result is taken in the cycle it shows.
module dirty_rect_coalescing_table import drc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [14:0] i_rect_left,
    input  logic [14:0] i_rect_top,
    input  logic [13:0] i_rect_width,
    input  logic [13:0] i_rect_height,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [12:0] o_out_left,
    output logic [12:0] o_out_top,
    output logic [13:0] o_out_width,
    output logic [13:0] o_out_height,
    output logic [4:0]  o_entry_count,
    output logic        o_last
);

    t_cmd  cmd;
    t_stat stat;
    logic [13:0] r_sw, r_sh;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= 14'd1024;
            r_sh <= 14'd768;
        end else if (i_cfg_valid) begin
            if (i_cfg_index) r_sh <= i_cfg_data;
            else             r_sw <= i_cfg_data;
        end
    end

    drc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    drc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_sw          (r_sw),
        .i_sh          (r_sh),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_left    (o_out_left),
        .o_out_top     (o_out_top),
        .o_out_width   (o_out_width),
        .o_out_height  (o_out_height),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import drc_pkg::*;

    localparam int Depth = 16;
    localparam int CycleLimit = 400000;
    localparam int RandItems = 280;

    typedef struct {
        logic [2:0]  status;
        logic [12:0] left;
        logic [12:0] top;
        logic [13:0] width;
        logic [13:0] height;
        logic [4:0]  count;
        logic        last;
    } t_res;

    typedef struct {
        longint l, t, w, h;
    } t_box;

    typedef struct {
        logic        kind;
        logic [14:0] left;
        logic [14:0] top;
        logic [13:0] width;
        logic [13:0] height;
        logic        has_exp;
        logic [2:0]  exp_status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = 1'b0;
    logic [14:0] i_rect_left = '0;
    logic [14:0] i_rect_top = '0;
    logic [13:0] i_rect_width = '0;
    logic [13:0] i_rect_height = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [13:0] i_cfg_data = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [12:0] o_out_left;
    logic [12:0] o_out_top;
    logic [13:0] o_out_width;
    logic [13:0] o_out_height;
    logic [4:0]  o_entry_count;
    logic        o_last;

    dirty_rect_coalescing_table dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_box   damage_tab[Depth];
    int     damage_cnt;
    longint scr_w, scr_h;
    t_res   pending_results[$];
    int     fails = 0;
    int     cycles = 0;

    function automatic bit strict_overlap(t_box a, t_box b);
        longint ar, ab, br, bb;
        ar = a.l + a.w - 1; ab = a.t + a.h - 1;
        br = b.l + b.w - 1; bb = b.t + b.h - 1;
        return b.l < ar && br > a.l && b.t < ab && bb > a.t;
    endfunction

    function automatic t_res make_res(logic [2:0] st, t_box r, int cnt, bit lst);
        t_res x;
        x.status = st; x.left = r.l[12:0]; x.top = r.t[12:0];
        x.width = r.w[13:0]; x.height = r.h[13:0];
        x.count = cnt[4:0]; x.last = lst;
        return x;
    endfunction

    function automatic longint clamp_dim(longint v);
        if (v < 1) return 1;
        if (v > 8192) return 8192;
        return v;
    endfunction

    task automatic predict_damage(logic kind, logic [14:0] l, logic [14:0] t,
                                  logic [13:0] w, logic [13:0] h);
        t_box zero, inr, scr, c, nr, e, k[$];
        bit add;
        bit keep;
        longint bl, bt, br, bb, bw, bh;
        zero = '{0, 0, 0, 0};
        if (kind) begin
            if (damage_cnt == 0) begin
                pending_results.push_back(make_res(ST_EMPTY, zero, 0, 1));
            end else begin
                for (int i = 0; i < damage_cnt; i++)
                    pending_results.push_back(make_res(ST_DRAIN, damage_tab[i], 0,
                                                       i == damage_cnt - 1));
                damage_cnt = 0;
            end
            return;
        end
        inr.l = longint'($signed(l)); inr.t = longint'($signed(t));
        inr.w = longint'(w); inr.h = longint'(h);
        scr = '{0, 0, clamp_dim(scr_w), clamp_dim(scr_h)};
        if (!strict_overlap(inr, scr)) begin
            pending_results.push_back(make_res(ST_OFF, zero, damage_cnt, 1));
            return;
        end
        c.l = inr.l > 0 ? inr.l : 0;
        c.t = inr.t > 0 ? inr.t : 0;
        br = inr.l + inr.w - 1; if (br > scr.w - 1) br = scr.w - 1;
        bb = inr.t + inr.h - 1; if (bb > scr.h - 1) bb = scr.h - 1;
        c.w = br - c.l + 1; c.h = bb - c.t + 1;
        nr = c; add = 1;
        for (int i = 0; i < damage_cnt; i++) begin
            e = damage_tab[i]; keep = 1;
            if (e.l == c.l && e.t == c.t && e.w == c.w && e.h == c.h) begin
                add = 0;
            end else if (strict_overlap(e, c)) begin
                bl = e.l < c.l ? e.l : c.l;
                bt = e.t < c.t ? e.t : c.t;
                br = e.l + e.w - 1; if (c.l + c.w - 1 > br) br = c.l + c.w - 1;
                bb = e.t + e.h - 1; if (c.t + c.h - 1 > bb) bb = c.t + c.h - 1;
                bw = br - bl + 1; bh = bb - bt + 1;
                if (bw * bh <= e.w * e.h + c.w * c.h) begin
                    keep = 0; nr = '{bl, bt, bw, bh};
                end
            end
            if (keep) k.push_back(e);
        end
        damage_cnt = k.size();
        foreach (k[i]) damage_tab[i] = k[i];
        if (!add)
            pending_results.push_back(make_res(ST_DUP, c, damage_cnt, 1));
        else if (damage_cnt >= Depth)
            pending_results.push_back(make_res(ST_FULL, nr, damage_cnt, 1));
        else begin
            damage_tab[damage_cnt] = nr; damage_cnt++;
            pending_results.push_back(make_res(ST_STORED, nr, damage_cnt, 1));
        end
    endtask

    // compare every result word against the oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word status=%0d", o_status);
                fails++;
            end else begin
                t_res x;
                x = pending_results.pop_front();
                if (o_status !== x.status) begin
                    $error("status exp %0d got %0d", x.status, o_status); fails++;
                end
                if (o_out_left !== x.left) begin
                    $error("out_left exp %0d got %0d", x.left, o_out_left); fails++;
                end
                if (o_out_top !== x.top) begin
                    $error("out_top exp %0d got %0d", x.top, o_out_top); fails++;
                end
                if (o_out_width !== x.width) begin
                    $error("out_width exp %0d got %0d", x.width, o_out_width); fails++;
                end
                if (o_out_height !== x.height) begin
                    $error("out_height exp %0d got %0d", x.height, o_out_height);
                    fails++;
                end
                if (o_entry_count !== x.count) begin
                    $error("entry_count exp %0d got %0d", x.count, o_entry_count);
                    fails++;
                end
                if (o_last !== x.last) begin
                    $error("last exp %0d got %0d", x.last, o_last); fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CycleLimit) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    bit quiet_stretch;

    task automatic send_word(logic kind, logic [14:0] l, logic [14:0] t,
                             logic [13:0] w, logic [13:0] h);
        while (!quiet_stretch && $urandom_range(99) < 8) @(posedge i_clk);
        start <= 1'b1; i_kind <= kind; i_rect_left <= l; i_rect_top <= t;
        i_rect_width <= w; i_rect_height <= h;
        @(posedge i_clk);
        // busy still holds its pre-edge value here, so the loop ends at the accepting edge
        while (busy) @(posedge i_clk);
        predict_damage(kind, l, t, w, h);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_screen(logic idx, logic [13:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx) scr_h = v; else scr_w = v;
    endtask

    function automatic logic [14:0] rand_coord(longint span);
        int r;
        r = $urandom_range(99);
        if (r < 10) return 15'($urandom);
        if (r < 20) return 15'(-$signed(32'($urandom_range(40))));
        return 15'($urandom_range(32'(span > 1 ? span - 1 : 0)));
    endfunction

    function automatic logic [13:0] rand_size(longint span);
        int r;
        r = $urandom_range(99);
        if (r < 8) return 14'($urandom);
        if (r < 14) return 14'($urandom_range(2));
        return 14'($urandom_range(32'(span / 3 + 2), 1));
    endfunction

    t_row stim_rows[$];

    initial begin
        bit is_drain;
        logic [14:0] cl;
        logic [14:0] ct;
        longint sw;
        longint sh;
        damage_cnt = 0; scr_w = 1024; scr_h = 768; quiet_stretch = 0;
        stim_rows = '{
            '{1, 0, 0, 0, 0, 1, ST_EMPTY},
            '{0, 15'h4000, 15'h4000, 14'h3fff, 14'h3fff, 0, 0},
            '{0, 15'h3fff, 15'h3fff, 14'h3fff, 14'h3fff, 1, ST_OFF},
            '{0, 15'h7fff, 0, 0, 10, 1, ST_OFF},
            '{0, 10, 10, 20, 20, 1, ST_STORED},
            '{0, 10, 10, 20, 20, 1, ST_DUP},
            '{0, 20, 20, 20, 20, 0, 0},
            '{0, 100, 100, 1, 1, 0, 0},
            '{0, 1023, 767, 100, 100, 0, 0},
            '{0, 15'h7ff0, 15'h7ff0, 30, 30, 0, 0},
            '{0, 500, 500, 2, 2, 0, 0},
            '{1, 0, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 1, ST_EMPTY}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (stim_rows[i]) begin
            send_word(stim_rows[i].kind, stim_rows[i].left, stim_rows[i].top,
                      stim_rows[i].width, stim_rows[i].height);
            if (stim_rows[i].has_exp &&
                pending_results[$].status !== stim_rows[i].exp_status) begin
                $error("status exp %0d got %0d (table row %0d)",
                       stim_rows[i].exp_status, pending_results[$].status, i);
                fails++;
            end
        end
        // fill past capacity with disjoint small squares
        for (int i = 0; i < Depth + 2; i++)
            send_word(0, 15'(i * 40), 15'(i * 30), 5, 5);
        send_word(1, 0, 0, 0, 0);
        for (int n = 0; n < RandItems; n++) begin
            if (n % 60 == 0) begin
                case ((n / 60) % 6)
                    0: begin sw = 64; sh = 48; end
                    1: begin sw = 0; sh = 1; end
                    2: begin sw = 14'h3fff; sh = 8192; end
                    3: begin sw = 8192; sh = 0; end
                    4: begin sw = 1; sh = 14'h3fff; end
                    default: begin sw = 200; sh = 150; end
                endcase
                write_screen(0, 14'(sw));
                write_screen(1, 14'(sh));
            end
            quiet_stretch = (n >= 120 && n < 180);
            sw = clamp_dim(scr_w); sh = clamp_dim(scr_h);
            is_drain = $urandom_range(99) < 7;
            cl = rand_coord(sw); ct = rand_coord(sh);
            send_word(is_drain, cl, ct, rand_size(sw), rand_size(sh));
        end
        send_word(1, 0, 0, 0, 0);
        wait_idle();
        if (fails == 0 && pending_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
